// ===== rtl/core/tct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tct_pkg: shared types and constants of the TCP connection tracker
// Flow phases, event codes, table entry layouts and the control bundles
// between controller and datapath.
// ----------------------------------------------------------------------------
package tct_pkg;

	localparam int FLOW_ENTRIES_DEF = 64;
	localparam int PAIR_ENTRIES_DEF = 64;

	localparam int CNT_W = 7;
	localparam logic [CNT_W-1:0] CNT_MAX = 7'd127;

	// flow phases
	localparam logic [1:0] PH_SYN    = 2'd0;
	localparam logic [1:0] PH_SYNACK = 2'd1;
	localparam logic [1:0] PH_EST    = 2'd2;
	localparam logic [1:0] PH_FINACK = 2'd3;

	// result event codes
	localparam logic [2:0] EV_NONE  = 3'd0;
	localparam logic [2:0] EV_ADDED = 3'd1;
	localparam logic [2:0] EV_EST   = 3'd2;
	localparam logic [2:0] EV_REL   = 3'd3;
	localparam logic [2:0] EV_RESET = 3'd4;
	localparam logic [2:0] EV_IGN   = 3'd5;

	typedef struct packed {
		logic [31:0] server_ip;
		logic [31:0] client_ip;
		logic [15:0] server_port;
		logic [15:0] client_port;
		logic [1:0]  phase;
	} flow_ent_t;

	typedef struct packed {
		logic [31:0]      server_ip;
		logic [31:0]      client_ip;
		logic [CNT_W-1:0] count;
	} pair_ent_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic fstep;
		logic fapply;
		logic pstep;
		logic papply;
	} tct_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic fdone;
		logic pdone;
		logic need_pair;
	} tct_sts_t;

endpackage

// ===== rtl/core/tct_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tct_ctrl: request sequencer
// Steps one request through flow scan and update (packets), pair scan and
// update (queries, counter changes) and the one-cycle result strobe.
// ----------------------------------------------------------------------------
module tct_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              op,
	input  tct_pkg::tct_sts_t sts,
	output tct_pkg::tct_cmd_t cmd,
	output logic              busy,
	output logic              done
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_FSCAN  = 3'd1;
	localparam logic [2:0] S_FAPPLY = 3'd2;
	localparam logic [2:0] S_PSCAN  = 3'd3;
	localparam logic [2:0] S_PAPPLY = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	logic [2:0] state_q, state_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = op ? S_PSCAN : S_FSCAN;
				end
			end
			S_FSCAN: begin
				cmd.fstep = 1'b1;
				if (sts.fdone) state_d = S_FAPPLY;
			end
			S_FAPPLY: begin
				cmd.fapply = 1'b1;
				state_d    = sts.need_pair ? S_PSCAN : S_DONE;
			end
			S_PSCAN: begin
				cmd.pstep = 1'b1;
				if (sts.pdone) state_d = S_PAPPLY;
			end
			S_PAPPLY: begin
				cmd.papply = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

endmodule

// ===== rtl/core/tct_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tct_dp: flow and pair tables with their scan units
// Each table is a memory scanned one entry per cycle with a registered
// read; match and lowest-free index are captured, then at most one entry updated.
// ----------------------------------------------------------------------------
module tct_dp #(
	parameter int FLOW_ENTRIES = tct_pkg::FLOW_ENTRIES_DEF,
	parameter int PAIR_ENTRIES = tct_pkg::PAIR_ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tct_pkg::tct_cmd_t cmd,
	output tct_pkg::tct_sts_t sts,
	input  logic              op,
	input  logic [31:0]       src_addr,
	input  logic [31:0]       dst_addr,
	input  logic [15:0]       src_port,
	input  logic [15:0]       dst_port,
	input  logic              syn_flag,
	input  logic              ack_flag,
	input  logic              fin_flag,
	input  logic              rst_flag,
	input  logic [31:0]       query_addr,
	output logic              status,
	output logic [2:0]        event_res,
	output logic [6:0]        conn_count
);

	localparam int FAW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
	localparam int PAW = (PAIR_ENTRIES > 1) ? $clog2(PAIR_ENTRIES) : 1;
	localparam logic [FAW:0] FEND = (FAW+1)'(FLOW_ENTRIES);
	localparam logic [PAW:0] PEND = (PAW+1)'(PAIR_ENTRIES);

	// latched request
	logic        op_q, syn_q, ack_q, fin_q, rst_q;
	logic [31:0] sa_q, da_q, qa_q;
	logic [15:0] sp_q, dp_q;

	// tables
	tct_pkg::flow_ent_t flow_mem [FLOW_ENTRIES];
	tct_pkg::pair_ent_t pair_mem [PAIR_ENTRIES];
	logic [FLOW_ENTRIES-1:0] flow_vld_q;
	logic [PAIR_ENTRIES-1:0] pair_vld_q;

	// scan state
	logic [FAW:0]       fi_q;
	logic [PAW:0]       pi_q;
	logic               fact_s1, pact_s1, fvld_s1, pvld_s1;
	logic [FAW-1:0]     fidx_s1;
	logic [PAW-1:0]     pidx_s1;
	tct_pkg::flow_ent_t frd_s1;
	tct_pkg::pair_ent_t prd_s1;

	logic               fhit_q, ffree_q, phit_q, pfree_q;
	logic [FAW-1:0]     fhit_idx_q, ffree_idx_q;
	logic [PAW-1:0]     phit_idx_q, pfree_idx_q;
	tct_pkg::flow_ent_t fent_q;
	logic [6:0]         pcnt_q;
	logic               pinc_q, pdec_q;

	// results
	logic       st_q;
	logic [2:0] ev_q;
	logic [6:0] sum_q;

	// flow update decision
	logic               f_we, f_set, f_clr, f_inc, f_dec, f_err;
	logic [FAW-1:0]     f_waddr;
	tct_pkg::flow_ent_t f_wdata;
	logic [2:0]         f_ev;

	// pair update decision
	logic               p_we, p_set, p_clr, p_err;
	logic [PAW-1:0]     p_waddr;
	tct_pkg::pair_ent_t p_wdata;
	logic [6:0]         p_dec;

	logic fwd_m, rev_m, pmatch, qmatch;
	logic [7:0] sum_x;

	// request latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op;
			sa_q  <= src_addr;
			da_q  <= dst_addr;
			sp_q  <= src_port;
			dp_q  <= dst_port;
			syn_q <= syn_flag;
			ack_q <= ack_flag;
			fin_q <= fin_flag;
			rst_q <= rst_flag;
			qa_q  <= query_addr;
		end
	end

	// registered table reads
	always_ff @(posedge clk) begin
		frd_s1  <= flow_mem[fi_q[FAW-1:0]];
		prd_s1  <= pair_mem[pi_q[PAW-1:0]];
		fidx_s1 <= fi_q[FAW-1:0];
		pidx_s1 <= pi_q[PAW-1:0];
		fvld_s1 <= flow_vld_q[fi_q[FAW-1:0]];
		pvld_s1 <= pair_vld_q[pi_q[PAW-1:0]];
	end

	// table writes
	always_ff @(posedge clk) begin
		if (f_we) flow_mem[f_waddr] <= f_wdata;
	end

	always_ff @(posedge clk) begin
		if (p_we) pair_mem[p_waddr] <= p_wdata;
	end

	// match on the compare stage
	assign fwd_m = (sa_q == frd_s1.server_ip) && (da_q == frd_s1.client_ip) &&
	               (sp_q == frd_s1.server_port) && (dp_q == frd_s1.client_port);
	assign rev_m = (sa_q == frd_s1.client_ip) && (da_q == frd_s1.server_ip) &&
	               (sp_q == frd_s1.client_port) && (dp_q == frd_s1.server_port);
	assign pmatch = (prd_s1.server_ip == fent_q.server_ip) &&
	                (prd_s1.client_ip == fent_q.client_ip);
	assign qmatch = (prd_s1.server_ip == qa_q);
	assign sum_x  = {1'b0, sum_q} + {1'b0, prd_s1.count};

	assign sts.fdone     = (fi_q == FEND) && !fact_s1;
	assign sts.pdone     = (pi_q == PEND) && !pact_s1;
	assign sts.need_pair = f_inc || f_dec;

	// flow update
	always_comb begin
		f_we    = 1'b0;
		f_set   = 1'b0;
		f_clr   = 1'b0;
		f_inc   = 1'b0;
		f_dec   = 1'b0;
		f_err   = 1'b0;
		f_ev    = tct_pkg::EV_NONE;
		f_waddr = fhit_idx_q;
		f_wdata = fent_q;
		if (cmd.fapply) begin
			if (!fhit_q) begin
				if (syn_q && !ack_q) begin
					if (ffree_q) begin
						f_we    = 1'b1;
						f_set   = 1'b1;
						f_waddr = ffree_idx_q;
						f_wdata = '{server_ip: da_q, client_ip: sa_q, server_port: dp_q,
						            client_port: sp_q, phase: tct_pkg::PH_SYN};
						f_ev    = tct_pkg::EV_ADDED;
					end else begin
						f_err = 1'b1;
					end
				end else begin
					f_ev = tct_pkg::EV_IGN;
				end
			end else if (rst_q) begin
				f_clr = 1'b1;
				if (fent_q.phase == tct_pkg::PH_EST ||
				    fent_q.phase == tct_pkg::PH_FINACK) begin
					f_dec = 1'b1;
					f_ev  = tct_pkg::EV_REL;
				end else begin
					f_ev = tct_pkg::EV_RESET;
				end
			end else if (fent_q.phase == tct_pkg::PH_SYN && syn_q && ack_q) begin
				f_we          = 1'b1;
				f_wdata.phase = tct_pkg::PH_SYNACK;
			end else if (fent_q.phase == tct_pkg::PH_SYNACK && ack_q && !syn_q) begin
				f_we          = 1'b1;
				f_wdata.phase = tct_pkg::PH_EST;
				f_inc         = 1'b1;
				f_ev          = tct_pkg::EV_EST;
			end else if (fent_q.phase == tct_pkg::PH_EST && fin_q && ack_q) begin
				f_we          = 1'b1;
				f_wdata.phase = tct_pkg::PH_FINACK;
			end else if (fent_q.phase == tct_pkg::PH_FINACK && ack_q) begin
				f_clr = 1'b1;
				f_dec = 1'b1;
				f_ev  = tct_pkg::EV_REL;
			end
		end
	end

	// pair update
	always_comb begin
		p_we    = 1'b0;
		p_set   = 1'b0;
		p_clr   = 1'b0;
		p_err   = 1'b0;
		p_waddr = phit_idx_q;
		p_dec   = (pcnt_q != 7'd0) ? pcnt_q - 7'd1 : 7'd0;
		p_wdata = '{server_ip: fent_q.server_ip, client_ip: fent_q.client_ip,
		            count: pcnt_q};
		if (cmd.papply && pinc_q) begin
			if (phit_q) begin
				p_we = 1'b1;
				if (pcnt_q < tct_pkg::CNT_MAX) p_wdata.count = pcnt_q + 7'd1;
			end else if (pfree_q) begin
				p_we          = 1'b1;
				p_set         = 1'b1;
				p_waddr       = pfree_idx_q;
				p_wdata.count = 7'd1;
			end else begin
				p_err = 1'b1;
			end
		end else if (cmd.papply && pdec_q) begin
			if (phit_q) begin
				p_we          = 1'b1;
				p_wdata.count = p_dec;
				p_clr         = (p_dec == 7'd0);
			end else begin
				p_err = 1'b1;
			end
		end
	end

	// scan counters, hit capture, valid bits and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fi_q       <= '0;
			pi_q       <= '0;
			fact_s1    <= 1'b0;
			pact_s1    <= 1'b0;
			fhit_q     <= 1'b0;
			ffree_q    <= 1'b0;
			phit_q     <= 1'b0;
			pfree_q    <= 1'b0;
			pinc_q     <= 1'b0;
			pdec_q     <= 1'b0;
			flow_vld_q <= '0;
			pair_vld_q <= '0;
			st_q       <= 1'b0;
			ev_q       <= tct_pkg::EV_NONE;
			sum_q      <= '0;
		end else begin
			if (cmd.load) begin
				fi_q    <= '0;
				pi_q    <= '0;
				fact_s1 <= 1'b0;
				pact_s1 <= 1'b0;
				fhit_q  <= 1'b0;
				ffree_q <= 1'b0;
				phit_q  <= 1'b0;
				pfree_q <= 1'b0;
				pinc_q  <= 1'b0;
				pdec_q  <= 1'b0;
				st_q    <= 1'b0;
				ev_q    <= tct_pkg::EV_NONE;
				sum_q   <= '0;
			end
			// flow scan
			if (cmd.fstep) begin
				fact_s1 <= (fi_q != FEND);
				if (fi_q != FEND) fi_q <= fi_q + 1'b1;
				if (fact_s1) begin
					if (fvld_s1 && (fwd_m || rev_m) && !fhit_q) fhit_q <= 1'b1;
					if (!fvld_s1 && !ffree_q) ffree_q <= 1'b1;
				end
			end
			// pair scan
			if (cmd.pstep) begin
				pact_s1 <= (pi_q != PEND);
				if (pi_q != PEND) pi_q <= pi_q + 1'b1;
				if (pact_s1 && pvld_s1) begin
					if (op_q && qmatch)
						sum_q <= (sum_x > 8'(tct_pkg::CNT_MAX)) ? tct_pkg::CNT_MAX :
						         sum_x[6:0];
					if (!op_q && pmatch && !phit_q) phit_q <= 1'b1;
				end
				if (pact_s1 && !pvld_s1 && !pfree_q) pfree_q <= 1'b1;
			end
			if (cmd.fapply) begin
				ev_q   <= f_ev;
				st_q   <= f_err;
				pinc_q <= f_inc;
				pdec_q <= f_dec;
				if (f_set) flow_vld_q[f_waddr] <= 1'b1;
				if (f_clr) flow_vld_q[fhit_idx_q] <= 1'b0;
			end
			if (cmd.papply) begin
				if (p_err) st_q <= 1'b1;
				if (p_set) pair_vld_q[p_waddr] <= 1'b1;
				if (p_clr) pair_vld_q[phit_idx_q] <= 1'b0;
			end
		end
	end

	// captured entry payloads
	always_ff @(posedge clk) begin
		if (cmd.fstep && fact_s1) begin
			if (fvld_s1 && (fwd_m || rev_m) && !fhit_q) begin
				fhit_idx_q <= fidx_s1;
				fent_q     <= frd_s1;
			end
			if (!fvld_s1 && !ffree_q) ffree_idx_q <= fidx_s1;
		end
		if (cmd.pstep && pact_s1) begin
			if (pvld_s1 && !op_q && pmatch && !phit_q) begin
				phit_idx_q <= pidx_s1;
				pcnt_q     <= prd_s1.count;
			end
			if (!pvld_s1 && !pfree_q) pfree_idx_q <= pidx_s1;
		end
	end

	assign status     = st_q;
	assign event_res  = ev_q;
	assign conn_count = sum_q;

endmodule

// ===== rtl/core/tcp_connection_tracker_top.sv =====
`timescale 1ns / 1ps
// A packet request scans the flow memory, then the pair memory when a counter is
// touched; a query scans only the pair memory. Both scans read one entry per cycle.
// One request at a time; busy is high meanwhile.
// done strobes one cycle with the result; the receiver cannot stall.
// Reset (arst_n low) empties both tables at once by clearing their valid bits.
// ----------------------------------------------------------------------------
// tcp_connection_tracker_top: TCP handshake tracker with per-pair counters
// Controller sequences the scans; datapath holds the tables.
// ----------------------------------------------------------------------------
module tcp_connection_tracker_top #(
	parameter int FLOW_ENTRIES = tct_pkg::FLOW_ENTRIES_DEF,
	parameter int PAIR_ENTRIES = tct_pkg::PAIR_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        op,
	input  logic [31:0] src_addr,
	input  logic [31:0] dst_addr,
	input  logic [15:0] src_port,
	input  logic [15:0] dst_port,
	input  logic        syn_flag,
	input  logic        ack_flag,
	input  logic        fin_flag,
	input  logic        rst_flag,
	input  logic [31:0] query_addr,
	output logic        done,
	output logic        status,
	output logic [2:0]  event_res,
	output logic [6:0]  conn_count
);

	tct_pkg::tct_cmd_t cmd;
	tct_pkg::tct_sts_t sts;

	tct_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	tct_dp #(
		.FLOW_ENTRIES (FLOW_ENTRIES),
		.PAIR_ENTRIES (PAIR_ENTRIES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.op         (op),
		.src_addr   (src_addr),
		.dst_addr   (dst_addr),
		.src_port   (src_port),
		.dst_port   (dst_port),
		.syn_flag   (syn_flag),
		.ack_flag   (ack_flag),
		.fin_flag   (fin_flag),
		.rst_flag   (rst_flag),
		.query_addr (query_addr),
		.status     (status),
		.event_res  (event_res),
		.conn_count (conn_count)
	);

endmodule

// ===== rtl/core/tct_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tct_checker: port-level checks of the tracker
// Request/result sequencing and result code consistency.
// ----------------------------------------------------------------------------
module tct_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic       status,
	input logic [2:0] event_res,
	input logic [6:0] conn_count
);

	// an accepted request holds the block busy next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("request accepted but not busy");

	// the result strobe appears only while a request is in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result without request");

	// one result per request
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe repeated");

	// a nonzero count only comes from a query, which has no event and no error
	a_count_query: assert property (@(posedge clk) disable iff (!arst_n)
		done && conn_count != 7'd0 |-> event_res == tct_pkg::EV_NONE && !status)
		else $error("count on a packet result");

	// event codes stay within the defined set
	a_event_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> event_res <= tct_pkg::EV_IGN) else $error("undefined event code");

endmodule

bind tcp_connection_tracker_top tct_checker u_tct_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.status     (status),
	.event_res  (event_res),
	.conn_count (conn_count)
);

// ===== sim/tcp_connection_tracker_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_connection_tracker_top_tb: self-checking bench for the connection tracker
// Drives packet and query requests through the start/busy handshake. An
// in-bench copy of the flow and pair tables predicts each result, and a
// monitor compares every done strobe against the oldest prediction.
// Directed handshakes and a full-table case run first, then random traffic.
// ----------------------------------------------------------------------------
module tcp_connection_tracker_top_tb;

	localparam int NFLOW     = 64;
	localparam int NPAIR     = 64;
	localparam int IDLE_LIMIT = 5000;
	localparam int RANDOM_REQS = 1440;

	typedef struct {
		logic        op;
		logic [31:0] sa;
		logic [31:0] da;
		logic [15:0] sp;
		logic [15:0] dp;
		logic        syn;
		logic        ack;
		logic        fin;
		logic        rst;
		logic [31:0] qa;
	} tcp_req_t;

	typedef struct {
		logic       status;
		logic [2:0] ev;
		logic [6:0] cnt;
	} tracker_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic op = 1'b0;
	logic [31:0] src_addr = '0;
	logic [31:0] dst_addr = '0;
	logic [15:0] src_port = '0;
	logic [15:0] dst_port = '0;
	logic syn_flag = 1'b0;
	logic ack_flag = 1'b0;
	logic fin_flag = 1'b0;
	logic rst_flag = 1'b0;
	logic [31:0] query_addr = '0;
	logic done;
	logic status;
	logic [2:0] event_res;
	logic [6:0] conn_count;

	// shadow flow and pair tables
	bit          fl_valid [NFLOW];
	logic [31:0] fl_srv [NFLOW];
	logic [31:0] fl_cli [NFLOW];
	logic [15:0] fl_sport [NFLOW];
	logic [15:0] fl_cport [NFLOW];
	logic [1:0]  fl_phase [NFLOW];
	bit          pr_valid [NPAIR];
	logic [31:0] pr_srv [NPAIR];
	logic [31:0] pr_cli [NPAIR];
	logic [6:0]  pr_count [NPAIR];

	tracker_result_t pending_results[$];
	int err_count = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	logic [31:0] addr_pool [6];

	tcp_connection_tracker_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.src_addr(src_addr), .dst_addr(dst_addr), .src_port(src_port),
		.dst_port(dst_port), .syn_flag(syn_flag), .ack_flag(ack_flag),
		.fin_flag(fin_flag), .rst_flag(rst_flag), .query_addr(query_addr),
		.done(done), .status(status), .event_res(event_res),
		.conn_count(conn_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// pair counter lookup, -1 when absent
	function automatic int pair_find(logic [31:0] srv, logic [31:0] cli);
		for (int i = 0; i < NPAIR; i++)
			if (pr_valid[i] && pr_srv[i] == srv && pr_cli[i] == cli)
				return i;
		return -1;
	endfunction

	function automatic bit pair_bump(logic [31:0] srv, logic [31:0] cli);
		int p;
		p = pair_find(srv, cli);
		if (p < 0) begin
			for (int i = 0; i < NPAIR; i++)
				if (!pr_valid[i]) begin
					p = i;
					break;
				end
			if (p < 0)
				return 1'b0;
			pr_valid[p] = 1'b1;
			pr_srv[p] = srv;
			pr_cli[p] = cli;
			pr_count[p] = '0;
		end
		if (pr_count[p] < tct_pkg::CNT_MAX)
			pr_count[p] = pr_count[p] + 7'd1;
		return 1'b1;
	endfunction

	function automatic bit pair_drop(logic [31:0] srv, logic [31:0] cli);
		int p;
		p = pair_find(srv, cli);
		if (p < 0)
			return 1'b0;
		if (pr_count[p] > 0)
			pr_count[p] = pr_count[p] - 7'd1;
		if (pr_count[p] == 0)
			pr_valid[p] = 1'b0;
		return 1'b1;
	endfunction

	function automatic int flow_match(tcp_req_t r);
		for (int i = 0; i < NFLOW; i++) begin
			if (!fl_valid[i])
				continue;
			if ((r.sa == fl_srv[i] && r.da == fl_cli[i] && r.sp == fl_sport[i] &&
					r.dp == fl_cport[i]) ||
					(r.sa == fl_cli[i] && r.da == fl_srv[i] && r.sp == fl_cport[i] &&
					r.dp == fl_sport[i]))
				return i;
		end
		return -1;
	endfunction

	function automatic int flows_open();
		int n;
		n = 0;
		for (int i = 0; i < NFLOW; i++)
			n += fl_valid[i];
		return n;
	endfunction

	// predict the result of one request and update the shadow tables
	function automatic tracker_result_t track_request(tcp_req_t r);
		tracker_result_t res;
		int f;
		int sum;
		res = '{1'b0, tct_pkg::EV_NONE, 7'd0};
		if (r.op) begin
			sum = 0;
			for (int i = 0; i < NPAIR; i++)
				if (pr_valid[i] && pr_srv[i] == r.qa) begin
					sum += pr_count[i];
					if (sum > tct_pkg::CNT_MAX)
						sum = tct_pkg::CNT_MAX;
				end
			res.cnt = sum[6:0];
			return res;
		end
		f = flow_match(r);
		if (f < 0) begin
			if (r.syn && !r.ack) begin
				for (int i = 0; i < NFLOW; i++)
					if (!fl_valid[i]) begin
						f = i;
						break;
					end
				if (f < 0) begin
					res.status = 1'b1;
				end else begin
					fl_valid[f] = 1'b1;
					fl_srv[f] = r.da;
					fl_cli[f] = r.sa;
					fl_sport[f] = r.dp;
					fl_cport[f] = r.sp;
					fl_phase[f] = tct_pkg::PH_SYN;
					res.ev = tct_pkg::EV_ADDED;
				end
			end else begin
				res.ev = tct_pkg::EV_IGN;
			end
		end else if (r.rst) begin
			if (fl_phase[f] == tct_pkg::PH_EST || fl_phase[f] == tct_pkg::PH_FINACK) begin
				res.status = !pair_drop(fl_srv[f], fl_cli[f]);
				res.ev = tct_pkg::EV_REL;
			end else begin
				res.ev = tct_pkg::EV_RESET;
			end
			fl_valid[f] = 1'b0;
		end else if (fl_phase[f] == tct_pkg::PH_SYN && r.syn && r.ack) begin
			fl_phase[f] = tct_pkg::PH_SYNACK;
		end else if (fl_phase[f] == tct_pkg::PH_SYNACK && r.ack && !r.syn) begin
			fl_phase[f] = tct_pkg::PH_EST;
			res.status = !pair_bump(fl_srv[f], fl_cli[f]);
			res.ev = tct_pkg::EV_EST;
		end else if (fl_phase[f] == tct_pkg::PH_EST && r.fin && r.ack) begin
			fl_phase[f] = tct_pkg::PH_FINACK;
		end else if (fl_phase[f] == tct_pkg::PH_FINACK && r.ack) begin
			res.status = !pair_drop(fl_srv[f], fl_cli[f]);
			fl_valid[f] = 1'b0;
			res.ev = tct_pkg::EV_REL;
		end
		return res;
	endfunction

	// send one request; bursts with random gaps between them
	task automatic send_request(tcp_req_t r);
		if (burst_left == 0) begin
			start = 1'b0;
			repeat ($urandom_range(1, 20)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) :
				$urandom_range(1, 12);
		end
		burst_left--;
		op = r.op;
		src_addr = r.sa;
		dst_addr = r.da;
		src_port = r.sp;
		dst_port = r.dp;
		syn_flag = r.syn;
		ack_flag = r.ack;
		fin_flag = r.fin;
		rst_flag = r.rst;
		query_addr = r.qa;
		start = 1'b1;
		do @(posedge clk); while (busy);
		pending_results.push_back(track_request(r));
		@(negedge clk);
	endtask

	function automatic tcp_req_t mk_pkt(logic [31:0] sa, logic [31:0] da, logic [15:0] sp,
			logic [15:0] dp, logic [3:0] flags);
		tcp_req_t r;
		r = '{1'b0, sa, da, sp, dp, flags[3], flags[2], flags[1], flags[0], $urandom};
		return r;
	endfunction

	function automatic tcp_req_t mk_query(logic [31:0] qa);
		tcp_req_t r;
		r = '{1'b1, $urandom, $urandom, 16'($urandom), 16'($urandom), 1'($urandom),
			1'($urandom), 1'($urandom), 1'($urandom), qa};
		return r;
	endfunction

	// packet of flow f in a random direction carrying the given flags
	function automatic tcp_req_t flow_pkt(int f, logic [3:0] flags);
		if ($urandom_range(0, 1))
			return mk_pkt(fl_cli[f], fl_srv[f], fl_cport[f], fl_sport[f], flags);
		return mk_pkt(fl_srv[f], fl_cli[f], fl_sport[f], fl_cport[f], flags);
	endfunction

	// flags {syn,ack,fin,rst} that move a flow on from its phase
	function automatic logic [3:0] advance_flags(int f);
		case (fl_phase[f])
			tct_pkg::PH_SYN: return 4'b1100;
			tct_pkg::PH_SYNACK: return 4'b0100;
			tct_pkg::PH_EST: return 4'b0110;
			default: return 4'b0100;
		endcase
	endfunction

	task automatic drive_flow_through(int f);
		while (fl_valid[f])
			send_request(flow_pkt(f, advance_flags(f)));
	endtask

	// handshakes, extremes, early reset, reset release and ignored packets
	task automatic test_handshakes();
		send_request(mk_query(32'h0));
		send_request(mk_pkt(32'h0, 32'hFFFF_FFFF, 16'h0, 16'hFFFF, 4'b0100));
		send_request(mk_pkt(32'h0, 32'hFFFF_FFFF, 16'h0, 16'hFFFF, 4'b1000));
		send_request(mk_pkt(32'h0, 32'hFFFF_FFFF, 16'h0, 16'hFFFF, 4'b1000));
		drive_flow_through(0);
		send_request(mk_pkt(32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'h0, 4'b1001));
		send_request(mk_pkt(32'h0, 32'hFFFF_FFFF, 16'h0, 16'hFFFF, 4'b0001));
		// early reset in SYN-ACK
		send_request(mk_pkt(32'h0A00_0001, 32'h0A00_0002, 16'd1234, 16'd80, 4'b1000));
		send_request(mk_pkt(32'h0A00_0002, 32'h0A00_0001, 16'd80, 16'd1234, 4'b1100));
		send_request(mk_pkt(32'h0A00_0001, 32'h0A00_0002, 16'd1234, 16'd80, 4'b0001));
		// reset on an established flow releases it
		send_request(mk_pkt(32'h0A00_0003, 32'hFFFF_FFFF, 16'd5, 16'd443, 4'b1000));
		send_request(mk_pkt(32'hFFFF_FFFF, 32'h0A00_0003, 16'd443, 16'd5, 4'b1100));
		send_request(mk_pkt(32'h0A00_0003, 32'hFFFF_FFFF, 16'd5, 16'd443, 4'b0100));
		send_request(mk_pkt(32'h0A00_0003, 32'hFFFF_FFFF, 16'd5, 16'd443, 4'b0100));
		send_request(mk_query(32'hFFFF_FFFF));
		send_request(mk_pkt(32'hFFFF_FFFF, 32'h0A00_0003, 16'd443, 16'd5, 4'b0001));
		send_request(mk_query(32'hFFFF_FFFF));
	endtask

	// fill the flow table with one server, overflow it, then drain
	task automatic test_table_full();
		int f;
		for (int i = 0; i < NFLOW; i++)
			send_request(mk_pkt(32'hC0A8_0000 + i, 32'h0A0A_0A0A, 16'(1000 + i), 16'd80,
				4'b1000));
		for (int i = 0; i < NFLOW; i += 2) begin
			send_request(flow_pkt(i, advance_flags(i)));
			send_request(flow_pkt(i, advance_flags(i)));
		end
		send_request(mk_query(32'h0A0A_0A0A));
		send_request(mk_pkt(32'h1, 32'h2, 16'd3, 16'd4, 4'b1010));
		send_request(mk_pkt(32'h1, 32'h2, 16'd3, 16'd4, 4'b0100));
		for (int i = 0; i < NFLOW; i++) begin
			f = i;
			if (i % 4 == 0)
				drive_flow_through(f);
			else
				send_request(flow_pkt(f, 4'b0001));
		end
		send_request(mk_query(32'h0A0A_0A0A));
	endtask

	// mostly well-formed handshakes over a small address pool, plus noise
	task automatic test_random_traffic();
		tcp_req_t r;
		int f;
		int pick;
		for (int n = 0; n < RANDOM_REQS; n++) begin
			pick = $urandom_range(0, 99);
			f = -1;
			if (flows_open() > 0 && pick < 60) begin
				do f = $urandom_range(0, NFLOW - 1); while (!fl_valid[f]);
			end
			if (f >= 0) begin
				if (flows_open() > 50 || $urandom_range(0, 19) == 0)
					r = flow_pkt(f, 4'b0001);
				else if ($urandom_range(0, 6) == 0)
					r = flow_pkt(f, 4'($urandom));
				else
					r = flow_pkt(f, advance_flags(f));
			end else if (pick < 80) begin
				r = mk_pkt(addr_pool[$urandom_range(0, 5)], addr_pool[$urandom_range(0, 5)],
					16'($urandom_range(0, 3)), $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom),
					4'b1000);
			end else if (pick < 90) begin
				r = mk_query($urandom_range(0, 3) ? addr_pool[$urandom_range(0, 5)] : $urandom);
			end else begin
				r = mk_pkt($urandom, $urandom, 16'($urandom), 16'($urandom), 4'($urandom));
			end
			send_request(r);
		end
	endtask

	// result monitor
	always @(posedge clk) begin
		tracker_result_t exp_res;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding");
				err_count++;
			end else begin
				exp_res = pending_results.pop_front();
				if (status !== exp_res.status) begin
					$error("status: expected %0d, got %0d", exp_res.status, status);
					err_count++;
				end
				if (event_res !== exp_res.ev) begin
					$error("event_res: expected %0d, got %0d", exp_res.ev, event_res);
					err_count++;
				end
				if (conn_count !== exp_res.cnt) begin
					$error("conn_count: expected %0d, got %0d", exp_res.cnt, conn_count);
					err_count++;
				end
			end
		end
	end

	// watchdog on cycles without any progress
	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int drain;
		addr_pool = '{32'h0, 32'hFFFF_FFFF, 32'h0A00_0001, 32'h0A00_0002, 32'hC0A8_0101,
			32'h7FFF_FFFF};
		foreach (fl_valid[i])
			fl_valid[i] = 1'b0;
		foreach (pr_valid[i])
			pr_valid[i] = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_handshakes();
		test_table_full();
		test_random_traffic();
		start = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		drain = 0;
		while (drain < 2 * (NFLOW + NPAIR + 8)) begin
			@(negedge clk);
			drain++;
		end
		if (err_count == 0 && pending_results.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/tct_pkg.sv
rtl/core/tct_ctrl.sv
rtl/core/tct_dp.sv
rtl/core/tcp_connection_tracker_top.sv
rtl/core/tct_checker.sv
sim/tcp_connection_tracker_top_tb.sv
